### hdl/gbf_pkg.sv
// gbf_pkg: shared types and constants of the glyph box finder
// used by gbf_ctrl, gbf_datapath, glyph_box_finder and gbf_checker
// no dependencies
`default_nettype none

package gbf_pkg;

    // width of a sheet dimension and of every coordinate
    localparam int DIM_W = 9;

    // command codes carried in the input tuser
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_NEW    = 2'd2,
        CMD_REWIND = 2'd3
    } command_t;

    // configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_TEST,
        ST_CK_TL,
        ST_CK_TR,
        ST_CK_BL,
        ST_CK_BR,
        ST_W_TEST,
        ST_W_CK,
        ST_H_TEST,
        ST_H_CK,
        ST_DONE_F,
        ST_DONE_NF
    } gbf_state_t;

    // which map pixel a read targets, relative to the scan position
    typedef enum logic [2:0] {
        PR_TL,
        PR_TR,
        PR_BL,
        PR_BR,
        PR_W,
        PR_H
    } probe_sel_t;

    typedef struct packed {
        logic       start;
        logic       wrap;
        logic       advance;
        logic       rd_en;
        probe_sel_t sel;
        logic       gw_inc;
        logic       gh_inc;
        logic       finish_found;
        logic       finish_nf;
    } gbf_cmd_t;

    typedef struct packed {
        logic y_end;
        logic rd_bg;
        logic w_more;
        logic h_more;
        logic out_free;
    } gbf_status_t;

endpackage

`default_nettype wire

### hdl/gbf_ctrl.sv
// gbf_ctrl: sequencer of the glyph box finder, drives the datapath by commands
// depends on gbf_pkg
`default_nettype none

module gbf_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [1:0]           in_command,
    output logic                      in_ready,
    input  wire gbf_pkg::gbf_status_t status,
    output gbf_pkg::gbf_cmd_t         cmd
);
    import gbf_pkg::*;

    gbf_state_t state_reg;
    gbf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_command == CMD_FIND)
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                state_next = status.y_end ? ST_DONE_NF : ST_CK_TL;
            end
            ST_CK_TL:
            begin
                state_next = status.rd_bg ? ST_CK_TR : ST_WRAP;
            end
            ST_CK_TR:
            begin
                state_next = status.rd_bg ? ST_CK_BL : ST_WRAP;
            end
            ST_CK_BL:
            begin
                state_next = status.rd_bg ? ST_CK_BR : ST_WRAP;
            end
            ST_CK_BR:
            begin
                state_next = status.rd_bg ? ST_WRAP : ST_W_TEST;
            end
            ST_W_TEST:
            begin
                state_next = status.w_more ? ST_W_CK : ST_H_TEST;
            end
            ST_W_CK:
            begin
                state_next = status.rd_bg ? ST_H_TEST : ST_W_TEST;
            end
            ST_H_TEST:
            begin
                state_next = status.h_more ? ST_H_CK : ST_DONE_F;
            end
            ST_H_CK:
            begin
                state_next = status.rd_bg ? ST_DONE_F : ST_H_TEST;
            end
            ST_DONE_F, ST_DONE_NF:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.sel  = PR_TL;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid && in_command == CMD_FIND;
            end
            ST_WRAP:
            begin
                cmd.wrap = 1'b1;
            end
            ST_TEST:
            begin
                cmd.rd_en = !status.y_end;
                cmd.sel   = PR_TL;
            end
            ST_CK_TL:
            begin
                cmd.rd_en   = status.rd_bg;
                cmd.sel     = PR_TR;
                cmd.advance = !status.rd_bg;
            end
            ST_CK_TR:
            begin
                cmd.rd_en   = status.rd_bg;
                cmd.sel     = PR_BL;
                cmd.advance = !status.rd_bg;
            end
            ST_CK_BL:
            begin
                cmd.rd_en   = status.rd_bg;
                cmd.sel     = PR_BR;
                cmd.advance = !status.rd_bg;
            end
            ST_CK_BR:
            begin
                // a glyph pixel at the bottom right closes the corner
                cmd.advance = status.rd_bg;
            end
            ST_W_TEST:
            begin
                cmd.rd_en = status.w_more;
                cmd.sel   = PR_W;
            end
            ST_W_CK:
            begin
                cmd.gw_inc = !status.rd_bg;
            end
            ST_H_TEST:
            begin
                cmd.rd_en = status.h_more;
                cmd.sel   = PR_H;
            end
            ST_H_CK:
            begin
                cmd.gh_inc = !status.rd_bg;
            end
            ST_DONE_F:
            begin
                cmd.finish_found = status.out_free;
            end
            ST_DONE_NF:
            begin
                cmd.finish_nf = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/gbf_datapath.sv
// gbf_datapath: configuration, background map memory, scan position and result register
// depends on gbf_pkg, commanded by gbf_ctrl
`default_nettype none

module gbf_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [gbf_pkg::DIM_W-1:0]  cfg_data,
    input  wire logic                       in_accept,
    input  wire logic [1:0]                 in_command,
    input  wire logic [31:0]                in_pixel,
    input  wire gbf_pkg::gbf_cmd_t          cmd,
    output gbf_pkg::gbf_status_t            status,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            out_found,
    output logic [31:0]                     out_box
);
    import gbf_pkg::*;

    localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int LW        = $clog2(MAP_DEPTH + 1);
    localparam int PW        = 2 * DIM_W + 1;
    localparam int CW        = DIM_W + 1;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
        logic [DIM_W-1:0] r;
        if (v < DIM_W'(2))
        begin
            r = DIM_W'(2);
        end
        else if (32'(v) > maxv)
        begin
            r = DIM_W'(maxv);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic [DIM_W-1:0] w_reg, h_reg;
    logic [31:0]      bg_reg;
    logic [LW-1:0]    load_index_reg;
    logic [DIM_W-1:0] cur_x_reg, cur_y_reg;
    logic [DIM_W-1:0] x_reg, y_reg;
    logic [DIM_W-1:0] gw_reg, gh_reg;
    logic             out_valid_reg;
    logic             out_found_reg;
    logic [31:0]      out_box_reg;
    logic             rd_data_reg;

    logic             map_mem [MAP_DEPTH];

    // load path
    logic [2*DIM_W-1:0] area;
    logic               load_ok;
    logic               wr_en;
    logic               wr_bit;
    logic [31:0]        bg_cmp;

    assign area    = w_reg * h_reg;
    assign load_ok = 32'(load_index_reg) < 32'(area);
    assign wr_en   = in_accept && in_command == CMD_LOAD && load_ok;
    assign bg_cmp  = (load_index_reg == '0) ? in_pixel : bg_reg;
    assign wr_bit  = in_pixel == bg_cmp;

    // probe address: row of the probe times the stride plus its column
    logic [CW-1:0]      px, py;
    logic [2*DIM_W-1:0] row_base;
    logic [PW-1:0]      lin_addr;
    logic [AW-1:0]      rd_addr;

    always_comb
    begin
        px = {1'b0, x_reg};
        py = {1'b0, y_reg};
        case (cmd.sel)
            PR_TL:
            begin
                px = {1'b0, x_reg};
                py = {1'b0, y_reg};
            end
            PR_TR:
            begin
                px = {1'b0, x_reg} + CW'(1);
                py = {1'b0, y_reg};
            end
            PR_BL:
            begin
                px = {1'b0, x_reg};
                py = {1'b0, y_reg} + CW'(1);
            end
            PR_BR:
            begin
                px = {1'b0, x_reg} + CW'(1);
                py = {1'b0, y_reg} + CW'(1);
            end
            PR_W:
            begin
                px = {1'b0, x_reg} + {1'b0, gw_reg} + CW'(1);
                py = {1'b0, y_reg} + CW'(1);
            end
            PR_H:
            begin
                px = {1'b0, x_reg} + CW'(1);
                py = {1'b0, y_reg} + {1'b0, gh_reg} + CW'(1);
            end
            default:
            begin
                px = {1'b0, x_reg};
                py = {1'b0, y_reg};
            end
        endcase
    end

    assign row_base = py[DIM_W-1:0] * w_reg;
    assign lin_addr = {1'b0, row_base} + PW'(px[DIM_W-1:0]);
    assign rd_addr  = AW'(lin_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[AW'(load_index_reg)] <= wr_bit;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // scan status
    logic [DIM_W-1:0] w_m1, h_m1;
    logic [CW-1:0]    w_end, h_end;
    logic             x_edge;
    logic             keep_y;

    assign w_m1   = w_reg - DIM_W'(1);
    assign h_m1   = h_reg - DIM_W'(1);
    assign x_edge = x_reg >= w_m1;
    assign w_end  = {1'b0, x_reg} + {1'b0, gw_reg} + CW'(1);
    assign h_end  = {1'b0, y_reg} + {1'b0, gh_reg} + CW'(1);
    // a cursor parked at column zero on or below the last row stays put
    assign keep_y = cur_x_reg == '0 && cur_y_reg >= h_m1;

    assign status.y_end    = y_reg >= h_m1;
    assign status.rd_bg    = rd_data_reg;
    assign status.w_more   = w_end < {1'b0, w_reg};
    assign status.h_more   = h_end < {1'b0, h_reg};
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg          <= clamp_dim(DIM_W'(256), MAX_WIDTH);
            h_reg          <= clamp_dim(DIM_W'(256), MAX_HEIGHT);
            bg_reg         <= '0;
            load_index_reg <= '0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WIDTH)
                begin
                    w_reg <= clamp_dim(cfg_data, MAX_WIDTH);
                end
                else
                begin
                    h_reg <= clamp_dim(cfg_data, MAX_HEIGHT);
                end
            end
            if (wr_en)
            begin
                bg_reg         <= bg_cmp;
                load_index_reg <= load_index_reg + LW'(1);
            end
            if (in_accept && in_command == CMD_NEW)
            begin
                load_index_reg <= '0;
                bg_reg         <= '0;
                cur_x_reg      <= '0;
                cur_y_reg      <= '0;
            end
            if (in_accept && in_command == CMD_REWIND)
            begin
                cur_x_reg <= '0;
                cur_y_reg <= '0;
            end
            if (cmd.finish_found)
            begin
                cur_x_reg <= x_reg + gw_reg;
                cur_y_reg <= y_reg;
            end
            if (cmd.finish_nf)
            begin
                cur_x_reg <= '0;
                cur_y_reg <= keep_y ? cur_y_reg : h_m1;
            end
            if (cmd.finish_found || cmd.finish_nf)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan position, box size and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg  <= cur_x_reg;
            y_reg  <= cur_y_reg;
            gw_reg <= DIM_W'(1);
            gh_reg <= DIM_W'(1);
        end
        if (cmd.wrap && x_edge)
        begin
            x_reg <= '0;
            y_reg <= y_reg + DIM_W'(1);
        end
        if (cmd.advance)
        begin
            x_reg <= x_reg + DIM_W'(1);
        end
        if (cmd.gw_inc)
        begin
            gw_reg <= gw_reg + DIM_W'(1);
        end
        if (cmd.gh_inc)
        begin
            gh_reg <= gh_reg + DIM_W'(1);
        end
        if (cmd.finish_found)
        begin
            out_found_reg <= 1'b1;
            out_box_reg   <= {gh_reg[7:0], gw_reg[7:0],
                              8'(y_reg + DIM_W'(1)), 8'(x_reg + DIM_W'(1))};
        end
        if (cmd.finish_nf)
        begin
            out_found_reg <= 1'b0;
            out_box_reg   <= '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_box   = out_box_reg;

endmodule

`default_nettype wire

### hdl/glyph_box_finder.sv
// glyph_box_finder: finds glyph boxes on a font sheet loaded pixel by pixel
// top level, depends on gbf_pkg, gbf_ctrl and gbf_datapath
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tuser command, tdata pixel
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tuser found, tdata box
//  cfg      | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// load, new image and rewind words are taken one per cycle while the block is idle
// a find is accepted, then at each scan position the block does a wrap check and a
// row test and reads the corner pixels in turn, then measures width and height one
// pixel read at a time up to a background pixel or the sheet edge, and posts the result
// a result still waiting in m_axis holds the next find in its done state, and the
// input stays stalled until that result is taken; rst_n resets width and height
// to their defaults and clears load count, background color and cursor, not the map
`default_nettype none

module glyph_box_finder #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [31:0]               s_axis_tdata,  // [31:0] pixel
    input  wire logic [1:0]                s_axis_tuser,  // [1:0] command
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // [7:0] glyph_x, [15:8] glyph_y, [23:16] glyph_width, [31:24] glyph_height
    output logic [31:0]                    m_axis_tdata,
    output logic                           m_axis_tuser,  // [0] found
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic                      cfg_index,
    input  wire logic [gbf_pkg::DIM_W-1:0] cfg_data
);
    import gbf_pkg::*;

    gbf_cmd_t    cmd;
    gbf_status_t status;
    logic        in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    gbf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (s_axis_tuser),
        .in_ready   (s_axis_tready),
        .status     (status),
        .cmd        (cmd)
    );

    gbf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .in_command (s_axis_tuser),
        .in_pixel   (s_axis_tdata),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_found  (m_axis_tuser),
        .out_box    (m_axis_tdata)
    );

endmodule

`default_nettype wire

### hdl/gbf_checker.sv
// gbf_checker: port-level assertions for glyph_box_finder, bound to the top level
// depends on gbf_pkg
`default_nettype none

module gbf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    import gbf_pkg::*;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // a not-found result carries an all-zero box
    a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)
        else $error("not-found result with nonzero box");

    // a find occupies the block on the following cycle
    a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_FIND |=> !s_axis_tready)
        else $error("input ready right after a find word");

endmodule

bind glyph_box_finder gbf_checker u_gbf_checker (.*);

`default_nettype wire
